FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define BFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");

// Clocked check that also holds during reset.
`define BFC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`endif

FILE: hw/rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Types, constants and helpers of the bitmap font text console.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfc_pkg;

    // Glyph store geometry
    localparam int GLYPH_STORE_BYTES = 32768;
    localparam int STORE_AW          = $clog2(GLYPH_STORE_BYTES);
    localparam int BANK_DEPTH        = GLYPH_STORE_BYTES / 2;
    localparam int MAX_FONT_HEIGHT   = 32;
    localparam int MAX_FONT_WIDTH    = 16;
    localparam int LINE_W            = $clog2(MAX_FONT_HEIGHT);

    // Input kinds
    localparam logic [1:0] KIND_PRINT = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_PLACE = 2'd2;

    // Result ops
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_SCROLL = 1'b1;

    // Control characters
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] FIRST_HIGH_CODE = 8'd128;

    // Configuration register indexes
    localparam logic [2:0] REG_FONT_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FONT_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCREEN_COLS = 3'd2;
    localparam logic [2:0] REG_SCREEN_ROWS = 3'd3;
    localparam logic [2:0] REG_GLYPH_COUNT = 3'd4;
    localparam logic [2:0] REG_FORE_COLOUR = 3'd5;
    localparam logic [2:0] REG_BACK_COLOUR = 3'd6;

    typedef logic [STORE_AW-1:0] t_store_addr;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [14:0] font_addr;
        logic [7:0]  font_byte;
        logic [7:0]  new_col;
        logic [7:0]  new_row;
    } t_in_word;

    typedef struct packed {
        logic        op;
        logic [11:0] pixel_x;
        logic [12:0] pixel_y;
        logic [15:0] pattern;
        logic [23:0] fore_rgb;
        logic [23:0] back_rgb;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic        we;
        t_store_addr addr;
        logic [7:0]  data;
    } t_store_wr;

    typedef struct packed {
        logic        re;
        t_store_addr addr;
        logic        wide;   // two bytes per glyph row
    } t_store_rd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DRAW,
        ST_SCROLL
    } t_state;

    // Byte address folded onto the store size
    function automatic t_store_addr fold_addr(input logic [15:0] a);
        logic [STORE_AW+15:0] wide_a;
        wide_a = {{STORE_AW{1'b0}}, a};
        return wide_a[STORE_AW-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bfc_ram.sv
// ----------------------------------------------------------------------------
// bfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/bfc_glyph_store.sv
// ----------------------------------------------------------------------------
// bfc_glyph_store
// Glyph bytes in two banks (even and odd address); one glyph row per read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfc_glyph_store (
    input  wire logic                 i_clk,
    input  wire bfc_pkg::t_store_wr   i_wr,
    input  wire bfc_pkg::t_store_rd   i_rd,
    output logic               [15:0] o_row
);

    localparam int BANK_AW = bfc_pkg::STORE_AW - 1;

    logic [7:0]         even_data;
    logic [7:0]         odd_data;
    logic [BANK_AW-1:0] waddr;
    logic [BANK_AW-1:0] raddr;
    logic               r_odd;
    logic               r_wide;

    assign waddr = i_wr.addr[bfc_pkg::STORE_AW-1:1];
    assign raddr = i_rd.addr[bfc_pkg::STORE_AW-1:1];

    bfc_ram #(
        .WIDTH (8),
        .DEPTH (bfc_pkg::BANK_DEPTH)
    ) u_even (
        .i_clk   (i_clk),
        .i_we    (i_wr.we && !i_wr.addr[0]),
        .i_waddr (waddr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.re),
        .i_raddr (raddr),
        .o_rdata (even_data)
    );

    bfc_ram #(
        .WIDTH (8),
        .DEPTH (bfc_pkg::BANK_DEPTH)
    ) u_odd (
        .i_clk   (i_clk),
        .i_we    (i_wr.we && i_wr.addr[0]),
        .i_waddr (waddr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.re),
        .i_raddr (raddr),
        .o_rdata (odd_data)
    );

    // Byte lane select follows the read data
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_odd  <= i_rd.addr[0];
            r_wide <= i_rd.wide;
        end
    end

    // Wide rows start on an even byte
    always_comb begin
        if (r_wide) begin
            o_row = {even_data, odd_data};
        end else if (r_odd) begin
            o_row = {odd_data, 8'h00};
        end else begin
            o_row = {even_data, 8'h00};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_font_text_console_unit.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_console_unit
// Text console renderer: characters in, glyph row draw and scroll words out.
// ----------------------------------------------------------------------------
// A printable character is accepted, then a setup state (PREP) issues the
// first glyph-store row read, then the draw state (DRAW) emits one output
// word per cycle while the output is not stalled, with the next row read
// alongside; a cell that wraps on the bottom row adds a scroll word. The
// glyph store is read once per glyph row through two byte banks, so that
// pace is one row per cycle when not stalled. Font loads, cursor placement
// and NUL, CR, backspace and LF are handled in the idle state (an LF that
// scrolls goes on to a scroll word). The glyph store powers up with unknown
// contents and is never cleared: load every glyph byte that will be drawn.
// Configuration registers may only be written while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_font_text_console_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [23:0]         i_cfg_data,
    // input words
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire bfc_pkg::t_in_word   i_in_word,
    // output words
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output bfc_pkg::t_out_word       o_out_word
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  r_font_width;
    logic [5:0]  r_font_height;
    logic [7:0]  r_cols;
    logic [7:0]  r_rows;
    logic [9:0]  r_glyph_count;
    logic [23:0] r_fore;
    logic [23:0] r_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_width  <= 5'd8;
            r_font_height <= 6'd16;
            r_cols        <= 8'd80;
            r_rows        <= 8'd25;
            r_glyph_count <= 10'd256;
            r_fore        <= 24'hFFFFFF;
            r_back        <= 24'h000000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfc_pkg::REG_FONT_WIDTH:  r_font_width  <= i_cfg_data[4:0];
                bfc_pkg::REG_FONT_HEIGHT: r_font_height <= i_cfg_data[5:0];
                bfc_pkg::REG_SCREEN_COLS: r_cols        <= i_cfg_data[7:0];
                bfc_pkg::REG_SCREEN_ROWS: r_rows        <= i_cfg_data[7:0];
                bfc_pkg::REG_GLYPH_COUNT: r_glyph_count <= i_cfg_data[9:0];
                bfc_pkg::REG_FORE_COLOUR: r_fore        <= i_cfg_data;
                bfc_pkg::REG_BACK_COLOUR: r_back        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective geometry: zero acts as one, oversize clamps to the maximum
    logic [4:0] eff_w;
    logic [5:0] eff_h;
    logic [7:0] eff_cols;
    logic [7:0] eff_rows;
    logic       wide;

    always_comb begin
        if (r_font_width == 5'd0) begin
            eff_w = 5'd1;
        end else if (r_font_width > 5'(bfc_pkg::MAX_FONT_WIDTH)) begin
            eff_w = 5'(bfc_pkg::MAX_FONT_WIDTH);
        end else begin
            eff_w = r_font_width;
        end
        if (r_font_height == 6'd0) begin
            eff_h = 6'd1;
        end else if (r_font_height > 6'(bfc_pkg::MAX_FONT_HEIGHT)) begin
            eff_h = 6'(bfc_pkg::MAX_FONT_HEIGHT);
        end else begin
            eff_h = r_font_height;
        end
    end

    assign eff_cols = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign eff_rows = (r_rows == 8'd0) ? 8'd1 : r_rows;
    assign wide     = (eff_w > 5'd8);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    bfc_pkg::t_state      r_state, n_state;
    logic [7:0]           r_col, n_col;
    logic [7:0]           r_row, n_row;
    logic [7:0]           r_code, n_code;
    bfc_pkg::t_store_addr r_addr, n_addr;
    logic [11:0]          r_px, n_px;
    logic [12:0]          r_py, n_py;
    logic [bfc_pkg::LINE_W-1:0] r_line, n_line;
    logic                 r_ov, n_ov;
    bfc_pkg::t_out_word   r_out, n_out;

    logic in_fire;
    logic out_free;
    logic [7:0] sat_col;
    logic [7:0] sat_row;
    logic [8:0] sat_row_inc;
    logic       sat_bottom;
    logic       is_ctrl;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;

    // Cursor clamped to the current screen (it may have shrunk)
    assign sat_col     = (r_col >= eff_cols) ? eff_cols - 8'd1 : r_col;
    assign sat_row     = (r_row >= eff_rows) ? eff_rows - 8'd1 : r_row;
    assign sat_row_inc = {1'b0, sat_row} + 9'd1;
    assign sat_bottom  = (sat_row_inc >= {1'b0, eff_rows});
    assign is_ctrl     = (i_in_word.char_code inside
                          {bfc_pkg::CH_NUL, bfc_pkg::CH_CR, bfc_pkg::CH_BS});

    // Glyph start address: glyph * height * bytes per row
    logic        code_ok;
    logic [6:0]  glyph;
    logic [12:0] glyph_rows;
    logic [15:0] glyph_byte;
    logic [12:0] px_full;
    logic [13:0] py_full;

    assign code_ok    = (r_code < bfc_pkg::FIRST_HIGH_CODE) &&
                        ({2'b00, r_code} < r_glyph_count);
    assign glyph      = code_ok ? r_code[6:0] : 7'd0;
    assign glyph_rows = {6'd0, glyph} * {7'd0, eff_h};
    assign glyph_byte = wide ? {2'b00, glyph_rows, 1'b0} : {3'b000, glyph_rows};
    assign px_full    = {5'd0, r_col} * {8'd0, eff_w};
    assign py_full    = {6'd0, r_row} * {8'd0, eff_h};

    // End-of-glyph cursor advance
    logic [8:0] col_inc;
    logic [8:0] row_inc;
    logic       wrap;
    logic       bottom;
    logic       last_line;

    assign col_inc   = {1'b0, r_col} + 9'd1;
    assign row_inc   = {1'b0, r_row} + 9'd1;
    assign wrap      = (col_inc >= {1'b0, eff_cols});
    assign bottom    = (row_inc >= {1'b0, eff_rows});
    assign last_line = ({{(6 - bfc_pkg::LINE_W){1'b0}}, r_line} == eff_h - 6'd1);

    // ------------------------------------------------------------------
    // Glyph store
    // ------------------------------------------------------------------
    bfc_pkg::t_store_wr store_wr;
    bfc_pkg::t_store_rd store_rd;
    logic [15:0]        store_row;
    logic [15:0]        keep;

    assign store_wr.we   = in_fire && (i_in_word.kind == bfc_pkg::KIND_LOAD);
    assign store_wr.addr = bfc_pkg::fold_addr({1'b0, i_in_word.font_addr});
    assign store_wr.data = i_in_word.font_byte;

    bfc_glyph_store u_store (
        .i_clk (i_clk),
        .i_wr  (store_wr),
        .i_rd  (store_rd),
        .o_row (store_row)
    );

    // Left-aligned mask of font_width bits
    assign keep = ~(16'hFFFF >> eff_w);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfc_pkg::ST_IDLE: begin
                if (in_fire && i_in_word.kind == bfc_pkg::KIND_PRINT) begin
                    if (is_ctrl) begin
                        n_state = bfc_pkg::ST_IDLE;
                    end else if (i_in_word.char_code == bfc_pkg::CH_LF) begin
                        n_state = sat_bottom ? bfc_pkg::ST_SCROLL : bfc_pkg::ST_IDLE;
                    end else begin
                        n_state = bfc_pkg::ST_PREP;
                    end
                end
            end
            bfc_pkg::ST_PREP: begin
                n_state = bfc_pkg::ST_DRAW;
            end
            bfc_pkg::ST_DRAW: begin
                if (out_free && last_line) begin
                    n_state = (wrap && bottom) ? bfc_pkg::ST_SCROLL : bfc_pkg::ST_IDLE;
                end
            end
            bfc_pkg::ST_SCROLL: begin
                if (out_free) begin
                    n_state = bfc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_code = r_code;
        n_addr = r_addr;
        n_px   = r_px;
        n_py   = r_py;
        n_line = r_line;
        n_ov   = r_ov && !i_out_ready;
        n_out  = r_out;

        store_rd.re   = 1'b0;
        store_rd.addr = r_addr;
        store_rd.wide = wide;

        case (r_state)
            bfc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (i_in_word.kind)
                        bfc_pkg::KIND_PLACE: begin
                            n_col = (i_in_word.new_col >= eff_cols) ?
                                    eff_cols - 8'd1 : i_in_word.new_col;
                            n_row = (i_in_word.new_row >= eff_rows) ?
                                    eff_rows - 8'd1 : i_in_word.new_row;
                        end
                        bfc_pkg::KIND_PRINT: begin
                            n_col  = sat_col;
                            n_row  = sat_row;
                            n_code = i_in_word.char_code;
                            case (i_in_word.char_code)
                                bfc_pkg::CH_NUL: begin
                                end
                                bfc_pkg::CH_CR: begin
                                    n_col = 8'd0;
                                end
                                bfc_pkg::CH_BS: begin
                                    if (sat_col != 8'd0) begin
                                        n_col = sat_col - 8'd1;
                                    end
                                end
                                bfc_pkg::CH_LF: begin
                                    n_col = 8'd0;
                                    n_row = sat_bottom ? sat_row : sat_row_inc[7:0];
                                end
                                default: begin
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bfc_pkg::ST_PREP: begin
                // first row read; screen position of the cell
                n_addr        = bfc_pkg::fold_addr(glyph_byte);
                store_rd.re   = 1'b1;
                store_rd.addr = n_addr;
                n_px          = px_full[11:0];
                n_py          = py_full[12:0];
                n_line        = '0;
            end
            bfc_pkg::ST_DRAW: begin
                if (out_free) begin
                    n_ov          = 1'b1;
                    n_out.op      = bfc_pkg::OP_DRAW;
                    n_out.pixel_x = r_px;
                    n_out.pixel_y = r_py + 13'(r_line);
                    n_out.pattern = store_row & keep;
                    n_out.fore_rgb = r_fore;
                    n_out.back_rgb = r_back;
                    n_out.last    = last_line && !(wrap && bottom);
                    if (last_line) begin
                        if (wrap) begin
                            n_col = 8'd0;
                            n_row = bottom ? r_row : row_inc[7:0];
                        end else begin
                            n_col = col_inc[7:0];
                        end
                    end else begin
                        n_addr        = r_addr + (wide ? bfc_pkg::STORE_AW'(2)
                                                       : bfc_pkg::STORE_AW'(1));
                        store_rd.re   = 1'b1;
                        store_rd.addr = n_addr;
                        n_line        = r_line + 1'b1;
                    end
                end
            end
            bfc_pkg::ST_SCROLL: begin
                if (out_free) begin
                    n_ov           = 1'b1;
                    n_out.op       = bfc_pkg::OP_SCROLL;
                    n_out.pixel_x  = '0;
                    n_out.pixel_y  = '0;
                    n_out.pattern  = '0;
                    n_out.fore_rgb = r_fore;
                    n_out.back_rgb = r_back;
                    n_out.last     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfc_pkg::ST_IDLE;
            r_col   <= 8'd0;
            r_row   <= 8'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_ov    <= n_ov;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_addr <= n_addr;
        r_px   <= n_px;
        r_py   <= n_py;
        r_line <= n_line;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == bfc_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/bfc_checker.sv
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks of the text console unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bfc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire bfc_pkg::t_in_word  i_in_word,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire bfc_pkg::t_out_word o_out_word
);

    logic print_glyph;
    logic out_stall;
    logic out_more;
    logic out_scroll;
    logic scroll_clean;

    assign print_glyph = i_in_valid && o_in_ready &&
                         (i_in_word.kind == bfc_pkg::KIND_PRINT) &&
                         !(i_in_word.char_code inside
                           {bfc_pkg::CH_NUL, bfc_pkg::CH_LF, bfc_pkg::CH_CR, bfc_pkg::CH_BS});

    assign out_stall    = o_out_valid && !i_out_ready;
    assign out_more     = o_out_valid && !o_out_word.last;
    assign out_scroll   = o_out_valid && (o_out_word.op == bfc_pkg::OP_SCROLL);
    assign scroll_clean = (o_out_word.pixel_x == 12'd0) && (o_out_word.pixel_y == 13'd0) &&
                          (o_out_word.pattern == 16'd0) && o_out_word.last;

    // stalled output word stays put
    `BFC_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid && $stable(o_out_word))

    // more words pending for this input: no new input taken
    `BFC_ASSERT(a_busy_until_last, i_clk, i_rst_n, out_more |-> !o_in_ready)

    // a glyph occupies the sequencer
    `BFC_ASSERT(a_glyph_busy, i_clk, i_rst_n, print_glyph |=> !o_in_ready)

    // scroll words carry no position or pattern and close the input
    `BFC_ASSERT(a_scroll_form, i_clk, i_rst_n, out_scroll |-> scroll_clean)

    // reset empties the output register
    `BFC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind bitmap_font_text_console_unit bfc_checker u_bfc_checker (.*);

`default_nettype wire
